// File: sv/wide_state_hash_512_assert.svh
// Assertion macros for the wide state hash block.
// Used by the modules of the hash; no other dependency.
`ifndef WIDE_STATE_HASH_512_ASSERT_SVH
`define WIDE_STATE_HASH_512_ASSERT_SVH
`ifndef SYNTHESIS
`define WSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/wsh512_pkg.sv
// Types, constants and round tables of the wide state hash.
// No dependencies.
package wsh512_pkg;
    localparam int LANES = 8;
    typedef logic [63:0] t_word;
    typedef t_word [LANES-1:0] t_lanes;
    typedef logic [2:0] t_sel_row [LANES];

    typedef enum logic { REQ_APPEND = 1'b0, REQ_FINAL = 1'b1 } t_req;

    typedef struct packed {
        logic       fin;
        logic [6:0] dlen;
        t_lanes     blk;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RND1, ST_MUL, ST_RND2, ST_EMIT
    } t_state;

    localparam t_lanes START_WORDS = {
        64'hC1D64BA40F335E36, 64'h01886F0928403002,
        64'h0347045B5BF1827F, 64'h2767F0B153D27B7F,
        64'hF86C6A11D0C18E95, 64'h1082276BF3A27251,
        64'hF39CC0605CEDC834, 64'h9E3779B97F4A7C15};
    localparam t_lanes FIRST_INIT = {
        64'h3F84D5B5B5470917, 64'hC0AC29B7C97C50DD,
        64'hBE5466CF34E90C6C, 64'h452821E638D01377,
        64'h082EFA98EC4E6C89, 64'hA4093822299F31D0,
        64'h13198A2E03707344, 64'h243F6A8885A308D3};
    localparam t_lanes LANE_MULT = {
        64'h4F7C7B5757F59585, 64'hDA06C80ABB1185EB,
        64'hF4BF8D8D8C31D763, 64'h324E7738926CFBE5,
        64'hA784D9045190CFEF, 64'h62E7160F38B4DA57,
        64'hBF7158809CF4F3C7, 64'hB7E151628AED2A6B};
    localparam t_lanes SECOND_INIT = {
        64'h636920D871574E69, 64'h0801F2E2858EFC16,
        64'h24A19947B3916CF7, 64'hBA7C9045F12C7F99,
        64'hB8E1AFED6A267E96, 64'h2FFD72DBD01ADFB7,
        64'hD1310BA698DFB5AC, 64'h9216D5D98979FB1B};

    function automatic logic [23:0] sel_row(input logic [3:0] r);
        case (r)
            4'd0:  sel_row = {3'd1,3'd6,3'd5,3'd4,3'd7,3'd2,3'd0,3'd3};
            4'd1:  sel_row = {3'd4,3'd5,3'd7,3'd0,3'd3,3'd6,3'd2,3'd1};
            4'd2:  sel_row = {3'd3,3'd2,3'd6,3'd5,3'd1,3'd7,3'd4,3'd0};
            4'd3:  sel_row = {3'd0,3'd4,3'd2,3'd1,3'd5,3'd3,3'd6,3'd7};
            4'd4:  sel_row = {3'd6,3'd7,3'd0,3'd3,3'd2,3'd5,3'd1,3'd4};
            4'd5:  sel_row = {3'd5,3'd1,3'd3,3'd6,3'd0,3'd4,3'd7,3'd2};
            4'd6:  sel_row = {3'd7,3'd3,3'd1,3'd2,3'd4,3'd0,3'd5,3'd6};
            4'd7:  sel_row = {3'd2,3'd0,3'd4,3'd7,3'd6,3'd1,3'd3,3'd5};
            4'd8:  sel_row = {3'd3,3'd6,3'd7,3'd5,3'd1,3'd4,3'd2,3'd0};
            4'd9:  sel_row = {3'd4,3'd3,3'd1,3'd0,3'd6,3'd5,3'd7,3'd2};
            4'd10: sel_row = {3'd1,3'd5,3'd2,3'd6,3'd7,3'd0,3'd3,3'd4};
            4'd11: sel_row = {3'd5,3'd2,3'd6,3'd1,3'd0,3'd3,3'd4,3'd7};
            4'd12: sel_row = {3'd7,3'd0,3'd4,3'd3,3'd2,3'd6,3'd1,3'd5};
            4'd13: sel_row = {3'd2,3'd1,3'd5,3'd4,3'd3,3'd7,3'd0,3'd6};
            4'd14: sel_row = {3'd0,3'd4,3'd3,3'd7,3'd5,3'd2,3'd6,3'd1};
            default: sel_row = {3'd6,3'd7,3'd0,3'd2,3'd4,3'd1,3'd5,3'd3};
        endcase
    endfunction

    function automatic logic [47:0] rot_row(input logic [3:0] r);
        case (r)
            4'd0:  rot_row = {6'd40,6'd48,6'd56,6'd48,6'd8,6'd8,6'd48,6'd56};
            4'd1:  rot_row = {6'd8,6'd24,6'd56,6'd32,6'd8,6'd32,6'd56,6'd24};
            4'd2:  rot_row = {6'd8,6'd48,6'd48,6'd24,6'd16,6'd48,6'd32,6'd16};
            4'd3:  rot_row = {6'd24,6'd32,6'd48,6'd56,6'd56,6'd56,6'd8,6'd56};
            4'd4:  rot_row = {6'd16,6'd56,6'd56,6'd24,6'd32,6'd32,6'd16,6'd48};
            4'd5:  rot_row = {6'd56,6'd24,6'd32,6'd32,6'd56,6'd8,6'd56,6'd32};
            4'd6:  rot_row = {6'd48,6'd56,6'd48,6'd48,6'd56,6'd40,6'd32,6'd8};
            4'd7:  rot_row = {6'd8,6'd8,6'd8,6'd8,6'd8,6'd8,6'd8,6'd8};
            4'd8:  rot_row = {6'd24,6'd40,6'd48,6'd48,6'd40,6'd24,6'd56,6'd48};
            4'd9:  rot_row = {6'd24,6'd8,6'd8,6'd40,6'd8,6'd48,6'd32,6'd24};
            4'd10: rot_row = {6'd32,6'd32,6'd16,6'd32,6'd8,6'd40,6'd16,6'd8};
            4'd11: rot_row = {6'd40,6'd8,6'd32,6'd16,6'd16,6'd48,6'd32,6'd8};
            4'd12: rot_row = {6'd16,6'd8,6'd48,6'd8,6'd16,6'd48,6'd24,6'd32};
            4'd13: rot_row = {6'd24,6'd40,6'd8,6'd16,6'd8,6'd24,6'd48,6'd40};
            4'd14: rot_row = {6'd8,6'd48,6'd48,6'd8,6'd48,6'd16,6'd32,6'd8};
            default: rot_row = {6'd8,6'd8,6'd8,6'd8,6'd8,6'd8,6'd8,6'd8};
        endcase
    endfunction

    function automatic t_word rotl(input t_word v, input logic [5:0] r);
        rotl = (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction
endpackage

// File: sv/wsh512_if.sv
// Valid/ready channel interfaces of the wide state hash.
// No dependencies.
interface wsh512_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    modport source (output valid, req_type, data_byte, input ready);
    modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface wsh512_dig_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       last;
    modport source (output valid, digest_byte, last, input ready);
    modport sink (input valid, digest_byte, last, output ready);
endinterface

// File: sv/wsh512_front.sv
// Front end: collects bytes into blocks, pads on finalize, pushes jobs.
// Depends on wsh512_pkg and wsh512_if.
module wsh512_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [6:0]           i_dlen,
    wsh512_req_if.sink           req,
    input  logic                 i_q_full,
    output logic                 o_push,
    output wsh512_pkg::t_job     o_job
);
    import wsh512_pkg::*;

    logic [7:0] r_buf [64];
    logic [5:0] r_fill;
    logic       acc;
    logic       full_blk;
    logic [6:0] pad;

    assign req.ready = !i_q_full;
    assign acc = req.valid && req.ready;
    assign full_blk = (req.req_type == REQ_APPEND) && (r_fill == 6'd63);
    assign o_push = acc && (full_blk || req.req_type == REQ_FINAL);
    assign pad = 7'd64 - {1'b0, r_fill};

    always_comb begin
        o_job.fin  = req.req_type;
        o_job.dlen = (i_dlen > 7'd64) ? 7'd64 : i_dlen;
        for (int k = 0; k < 64; k++) begin
            if (6'(k) < r_fill) begin
                o_job.blk[k/8][8*(k%8) +: 8] = r_buf[k];
            end else if (6'(k) == r_fill && req.req_type == REQ_APPEND) begin
                o_job.blk[k/8][8*(k%8) +: 8] = req.data_byte;
            end else begin
                o_job.blk[k/8][8*(k%8) +: 8] = {1'b0, pad};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 6'd0;
        end else if (acc) begin
            r_fill <= (req.req_type == REQ_FINAL) ? 6'd0 : r_fill + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && req.req_type == REQ_APPEND) begin
            r_buf[r_fill] <= req.data_byte;
        end
    end
endmodule

// File: sv/wsh512_queue.sv
// Two-entry job queue between front and back end.
// Depends on wsh512_pkg.
module wsh512_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsh512_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output wsh512_pkg::t_job  o_job
);
    import wsh512_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    `include "wide_state_hash_512_assert.svh"
    `WSH_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `WSH_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `WSH_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !i_push && !i_pop, $stable(r_cnt))
endmodule

// File: sv/wsh512_back.sv
// Back end: runs compression rounds one per cycle, multiplies, emits digest.
// Depends on wsh512_pkg and wsh512_if.
module wsh512_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsh512_pkg::t_job  i_job,
    output logic              o_pop,
    wsh512_dig_if.source      dig
);
    import wsh512_pkg::*;

    t_state r_st, n_st;
    t_lanes r_chain, r_x, r_y;
    logic [3:0] r_rnd;
    logic [2:0] r_lane;
    logic [1:0] r_ph;
    logic [5:0] r_k;
    logic       r_fin;
    logic [6:0] r_dlen;
    logic [63:0] r_acc;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    t_word cur_y, cur_m;
    logic [23:0] sel;
    logic [47:0] rot;
    t_lanes rnd_out;
    logic pop;

    always_comb begin
        t_word s, t;
        sel = sel_row(r_rnd);
        rot = rot_row(r_rnd);
        for (int i = 0; i < LANES; i++) begin
            s = r_rnd[3] ? r_y[sel[3*i +: 3]] : r_x[sel[3*i +: 3]];
            if (r_rnd[3]) t = r_rnd[0] ? r_x[i] + s : r_x[i] ^ s;
            else t = r_rnd[0] ? r_y[i] + s : r_y[i] ^ s;
            rnd_out[i] = rotl(t, rot[6*i +: 6]);
        end
    end

    always_comb begin
        cur_y = r_y[r_lane];
        cur_m = LANE_MULT[r_lane];
        case (r_ph)
            2'd0: begin
                mul_a = cur_y[31:0];
                mul_b = cur_m[31:0];
            end
            2'd1: begin
                mul_a = cur_y[31:0];
                mul_b = cur_m[63:32];
            end
            default: begin
                mul_a = cur_y[63:32];
                mul_b = cur_m[31:0];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign pop = (r_st == ST_IDLE) && i_valid;
    assign o_pop = pop;
    assign dig.valid = r_st == ST_EMIT;
    assign dig.digest_byte = r_chain[r_k[5:3]][{r_k[2:0], 3'b000} +: 8];
    assign dig.last = ({1'b0, r_k} + 7'd1) == r_dlen;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_RND1;
            ST_RND1: if (r_rnd == 4'd7) n_st = ST_MUL;
            ST_MUL:  if (r_lane == 3'd7 && r_ph == 2'd2) n_st = ST_RND2;
            ST_RND2: if (r_rnd == 4'd15)
                         n_st = (r_fin && r_dlen != 7'd0) ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (dig.ready && dig.last) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_chain <= START_WORDS;
        end else begin
            r_st <= n_st;
            if (r_st == ST_RND2 && r_rnd == 4'd15) begin
                for (int i = 0; i < LANES; i++) r_chain[i] <= r_chain[i] ^ rnd_out[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_rnd <= 4'd0;
                r_k <= 6'd0;
                r_lane <= 3'd0;
                r_ph <= 2'd0;
                if (i_valid) begin
                    r_fin <= i_job.fin;
                    r_dlen <= i_job.dlen;
                    for (int i = 0; i < LANES; i++) r_x[i] <= r_chain[i] ^ i_job.blk[i];
                    r_y <= FIRST_INIT;
                end
            end
            ST_RND1: begin
                r_y <= rnd_out;
                r_rnd <= r_rnd + 4'd1;
            end
            ST_MUL: begin
                case (r_ph)
                    2'd0: begin
                        r_acc <= mul_p;
                        r_ph <= 2'd1;
                    end
                    2'd1: begin
                        r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
                        r_ph <= 2'd2;
                    end
                    default: begin
                        r_y[r_lane] <= {r_acc[63:32] + mul_p[31:0], r_acc[31:0]};
                        r_ph <= 2'd0;
                        r_lane <= r_lane + 3'd1;
                        if (r_lane == 3'd7) r_x <= SECOND_INIT;
                    end
                endcase
            end
            ST_RND2: begin
                r_x <= rnd_out;
                r_rnd <= r_rnd + 4'd1;
            end
            ST_EMIT: if (dig.ready) r_k <= r_k + 6'd1;
            default: ;
        endcase
    end

    `include "wide_state_hash_512_assert.svh"
    `WSH_ASSERT_NEXT(a_emit_hold, i_clk, i_rst_n,
        dig.valid && !dig.ready, dig.valid && $stable(r_k))
    `WSH_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_st == ST_IDLE)
    `WSH_ASSERT_IMPL(a_k_bound, i_clk, i_rst_n, dig.valid, {1'b0, r_k} < r_dlen)
endmodule

// File: sv/wide_state_hash_512.sv
// Top level of the wide state hash: front end, job queue, back end.
// Depends on wsh512_pkg, wsh512_if and the three submodules.
//
// Use: requests arrive on req (req_type, data_byte). Append requests are
// taken one per cycle and collect into a 64-byte block. A full block or a
// finalize request becomes a job in a two-entry queue; the front end
// stalls only when that queue is full. The back end works on one job at a
// time: a pop, 8 rounds one per cycle, a multiply pass (three 32x32
// steps per lane on one multiplier), then 8 more rounds; it pops the
// next job only once it is back in idle. On finalize, digest_len bytes
// (at most 64) follow on dig, one per accepted cycle, last set on the
// final byte. So bytes stream in at one per cycle while each block of
// 64 is compressed.
// Reset loads the start words and empties buffer and queue. A stalled
// receiver holds the current digest byte; the queue then fills and
// requests stall behind it. digest_len is written through i_cfg_we.
module wide_state_hash_512 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    wsh512_req_if.sink   req,
    wsh512_dig_if.source dig
);
    import wsh512_pkg::*;

    logic [6:0] r_dlen;
    logic push, full, pop, qv;
    t_job fjob, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dlen <= 7'd64;
        else if (i_cfg_we) r_dlen <= i_cfg_wdata;
    end

    wsh512_front u_front (.i_clk, .i_rst_n, .i_dlen(r_dlen), .req,
        .i_q_full(full), .o_push(push), .o_job(fjob));
    wsh512_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_job(fjob),
        .o_full(full), .i_pop(pop), .o_valid(qv), .o_job(qjob));
    wsh512_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .i_job(qjob),
        .o_pop(pop), .dig);
endmodule
